// ===== rtl/ils_pkg.sv =====
// Package for the indexed list store: sizes, operation and status codes,
// and the control word broadcast to the storage cells. No dependencies.
package ils_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 12;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rd;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

// ===== rtl/indexed_list_store.sv =====
// Indexed list store: ordered list of signed 32-bit values in a chain of
// cells, with read, insert head/tail/position and delete requests.
// Depends on ils_pkg and ils_cell.
//
// Usage:
//   Input channel i_valid/o_ready carries one request (i_op, i_position,
//   i_value). Output channel o_valid/i_ready returns one result per request
//   (o_read_value, o_status, o_count) in request order.
//   The list is updated at the edge the request is accepted: every cell
//   above the position, and on delete the cell at it, takes its neighbor's
//   entry in that same cycle, so the next request already sees the new list.
//   A read gates the addressed cell onto an OR tree; groups of 32 cells are
//   registered at acceptance and combined in the following stage.
//   Every result passes through the middle stage and the output register.
//   Throughput: one request per cycle while the receiver takes results.
//   When the receiver stalls, the result is held in the output register, one
//   more request is held in the middle stage, and then o_ready drops.
//   Reset clears the count and both result stages; entries need no clearing,
//   since only positions below the count are ever read.
module indexed_list_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic        [ils_pkg::OP_W-1:0]     i_op,
    input  logic signed [ils_pkg::POS_W-1:0]    i_position,
    input  logic signed [ils_pkg::DATA_W-1:0]   i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ils_pkg::DATA_W-1:0]   o_read_value,
    output logic        [ils_pkg::STATUS_W-1:0] o_status,
    output logic        [ils_pkg::CNT_W-1:0]    o_count
);
    import ils_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_neg;
    logic [CMP_W-1:0]     w_pos_u;
    logic [CMP_W-1:0]     w_cnt_u;
    logic                 w_below;
    t_cell_ctrl           w_ctrl;
    logic [DATA_W-1:0]    w_rd_const;
    logic [STATUS_W-1:0]  w_status;

    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [DATA_W-1:0] w_pick  [NUM_GROUPS*GROUP_SIZE];
    logic [DATA_W-1:0] w_grp   [NUM_GROUPS];

    logic                r_pend_valid;
    logic                r_pend_rd;
    logic [DATA_W-1:0]   r_pend_value;
    logic [STATUS_W-1:0] r_pend_status;
    logic [CNT_W-1:0]    r_pend_count;
    logic [DATA_W-1:0]   r_grp [NUM_GROUPS];
    logic [DATA_W-1:0]   w_tree;

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]    r_out_count;
    logic                w_out_load;

    assign w_out_load = r_pend_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_pend_valid || w_out_load;
    assign w_accept   = i_valid && o_ready;

    assign w_full  = (r_count == FULL_CNT);
    assign w_neg   = i_position[POS_W-1];
    assign w_pos_u = CMP_W'(i_position[POS_W-2:0]);
    assign w_cnt_u = CMP_W'(r_count);
    assign w_below = !w_neg && (w_pos_u < w_cnt_u);

    // request decode
    always_comb begin
        w_ctrl.ins   = 1'b0;
        w_ctrl.del   = 1'b0;
        w_ctrl.rd    = 1'b0;
        w_ctrl.pos   = w_pos_u[IDX_W-1:0];
        w_ctrl.value = i_value;
        w_rd_const   = '0;
        w_status     = ST_DONE;
        unique case (i_op)
            OP_READ: begin
                if (w_below) begin
                    w_ctrl.rd = 1'b1;
                end else begin
                    w_rd_const = '1;
                    w_status   = ST_RANGE;
                end
            end
            OP_INS_HEAD: begin
                w_ctrl.pos = '0;
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                end
            end
            OP_INS_TAIL: begin
                w_ctrl.pos = r_count[IDX_W-1:0];
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                end
            end
            OP_INS_POS: begin
                if (w_neg) begin
                    w_ctrl.pos = '0;
                end
                if (!w_neg && (w_pos_u > w_cnt_u)) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_below) begin
                    w_ctrl.del = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
        if (!w_accept) begin
            w_ctrl.ins = 1'b0;
            w_ctrl.del = 1'b0;
        end
    end

    always_comb begin
        priority if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.del) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end
        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (IDX_W'(k)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[k]),
            .o_pick  (w_pick[k])
        );
    end

    for (genvar k = CAPACITY; k < NUM_GROUPS*GROUP_SIZE; k++) begin : g_pad
        assign w_pick[k] = '0;
    end

    // read tree, first level
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        always_comb begin
            w_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                w_grp[g] = w_grp[g] | w_pick[g*GROUP_SIZE + j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                r_grp[g] <= w_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_accept) begin
            r_pend_valid <= 1'b1;
        end else if (w_out_load) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_rd     <= w_ctrl.rd;
            r_pend_value  <= w_rd_const;
            r_pend_status <= w_status;
            r_pend_count  <= n_count;
        end
    end

    // read tree, second level
    always_comb begin
        w_tree = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            w_tree = w_tree | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value  <= r_pend_rd ? w_tree : r_pend_value;
            r_out_status <= r_pend_status;
            r_out_count  <= r_pend_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

endmodule

// ===== rtl/ils_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts up or down
// from its neighbors on insert and delete, and gates its entry onto the read tree.
// Depends on ils_pkg.
module ils_cell (
    input  logic                      i_clk,
    input  ils_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ils_pkg::IDX_W-1:0] i_index,
    input  logic [ils_pkg::DATA_W-1:0] i_left,
    input  logic [ils_pkg::DATA_W-1:0] i_right,
    output logic [ils_pkg::DATA_W-1:0] o_entry,
    output logic [ils_pkg::DATA_W-1:0] o_pick
);
    import ils_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        priority if (i_ctrl.ins && (i_index > i_ctrl.pos)) begin
            n_entry = i_left;
        end else if (i_ctrl.ins && (i_index == i_ctrl.pos)) begin
            n_entry = i_ctrl.value;
        end else if (i_ctrl.del && (i_index >= i_ctrl.pos)) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_pick  = (i_ctrl.rd && (i_index == i_ctrl.pos)) ? r_entry : '0;

endmodule

// ===== rtl/ils_checker.sv =====
// Port-level checks for the indexed list store, bound to the top level.
// Depends on ils_pkg and indexed_list_store.
module ils_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [ils_pkg::DATA_W-1:0]   o_read_value,
    input logic        [ils_pkg::STATUS_W-1:0] o_status,
    input logic        [ils_pkg::CNT_W-1:0]    o_count
);
    import ils_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_value)
            && $stable(o_status) && $stable(o_count))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

// ===== verif/testbench.sv =====
// Testbench for indexed_list_store: directed and random read/insert/delete requests,
// with results checked against a scoreboard that keeps its own copy of the list.
// Depends on ils_pkg and the indexed_list_store RTL.
module testbench;
    import ils_pkg::*;

    localparam logic [OP_W-1:0] OP_LAST = {OP_W{1'b1}};
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 120;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [CNT_W-1:0]         count;
    } t_list_result;

    class t_list_scoreboard;
        logic signed [DATA_W-1:0] entries [CAPACITY];
        int n_entries;
        int errors;
        t_list_result expected_q[$];

        function void note_request(logic [OP_W-1:0] op, logic signed [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] value);
            int p;
            int slot;
            t_list_result res;
            p = pos;
            slot = -1;
            res.read_value = '0;
            res.status = ST_DONE;
            case (op)
                OP_READ: begin
                    if (p < 0 || p >= n_entries) begin
                        res.read_value = -1;
                        res.status = ST_RANGE;
                    end else begin
                        res.read_value = entries[p];
                    end
                end
                OP_INS_HEAD: begin
                    if (n_entries >= CAPACITY) res.status = ST_FULL;
                    else slot = 0;
                end
                OP_INS_TAIL: begin
                    if (n_entries >= CAPACITY) res.status = ST_FULL;
                    else slot = n_entries;
                end
                OP_INS_POS: begin
                    if (p > n_entries) res.status = ST_RANGE;
                    else if (n_entries >= CAPACITY) res.status = ST_FULL;
                    else slot = (p < 0) ? 0 : p;
                end
                OP_DELETE: begin
                    if (p < 0 || p >= n_entries) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (int i = p; i < n_entries - 1; i++) entries[i] = entries[i + 1];
                        n_entries--;
                    end
                end
                default: res.status = ST_RANGE;
            endcase
            if (slot >= 0) begin
                for (int i = n_entries; i > slot; i--) entries[i] = entries[i - 1];
                entries[slot] = value;
                n_entries++;
            end
            res.count = CNT_W'(n_entries);
            expected_q.push_back(res);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] read_value,
                                   logic [STATUS_W-1:0] status, logic [CNT_W-1:0] count);
            t_list_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: read_value %0d status %0d count %0d",
                       read_value, status, count);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, read_value);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic        [OP_W-1:0]     i_op;
    logic signed [POS_W-1:0]    i_position;
    logic signed [DATA_W-1:0]   i_value;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [DATA_W-1:0]   o_read_value;
    logic        [STATUS_W-1:0] o_status;
    logic        [CNT_W-1:0]    o_count;

    t_list_scoreboard sb = new();
    int burst_left;
    int hold_requests;
    int hold_served;
    int hold_left;
    int seg_left;
    int ready_mode;
    int cycle_count;

    indexed_list_store u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall segments, plus long holds on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                ready_mode = $urandom_range(2);
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (ready_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(99) < 65);
                default: i_ready <= (seg_left % 3 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_read_value, o_status, o_count);
    end

    task send_request(input logic [OP_W-1:0] op, input int pos, input logic [DATA_W-1:0] value);
        i_valid <= 1'b1;
        i_op <= op;
        i_position <= pos[POS_W-1:0];
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, pos[POS_W-1:0], value);
    endtask

    task pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task send_paced(input logic [OP_W-1:0] op, input int pos, input logic [DATA_W-1:0] value);
        send_request(op, pos, value);
        pace();
    endtask

    task wait_for_results();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // mostly legal positions, some just past the end, negative or arbitrary
    function automatic int pick_position(input int top);
        int r;
        r = $urandom_range(99);
        if (top >= 0 && r < 85) return $urandom_range(top);
        if (r < 90) return top + 1;
        if (r < 94) return -1;
        return $urandom;
    endfunction

    task send_random(input int ins_w, input int del_w, input int rd_w);
        int r;
        int pos;
        logic [OP_W-1:0] op;
        logic [DATA_W-1:0] value;
        r = $urandom_range(99);
        if ($urandom_range(19) == 0) value = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        else value = $urandom;
        if (r < ins_w) begin
            case ($urandom_range(2))
                0: op = OP_INS_HEAD;
                1: op = OP_INS_TAIL;
                default: op = OP_INS_POS;
            endcase
            pos = (op == OP_INS_POS) ? pick_position(sb.n_entries) : $urandom;
        end else if (r < ins_w + del_w) begin
            op = OP_DELETE;
            pos = pick_position(sb.n_entries - 1);
        end else if (r < ins_w + del_w + rd_w) begin
            op = OP_READ;
            pos = pick_position(sb.n_entries - 1);
        end else begin
            op = OP_W'($urandom_range(OP_DELETE + 1, OP_LAST));
            pos = $urandom;
        end
        send_paced(op, pos, value);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op <= OP_READ;
        i_position <= '0;
        i_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(0, 40);

        // directed: empty list, clamping, appends, range errors, unknown ops
        send_paced(OP_READ, 0, 32'h0);
        send_paced(OP_DELETE, 0, 32'h0);
        send_paced(OP_INS_POS, 1, 32'h1234_5678);
        send_paced(OP_INS_POS, -2048, 32'h8000_0000);
        send_paced(OP_INS_HEAD, 2047, 32'h7fff_ffff);
        send_paced(OP_INS_TAIL, 0, 32'hffff_ffff);
        send_paced(OP_INS_POS, 3, 32'h0);
        send_paced(OP_INS_POS, 2047, 32'h0bad_0bad);
        send_paced(OP_READ, -1, 32'h0);
        send_paced(OP_READ, 4, 32'h0);
        send_paced(OP_READ, 0, 32'h0);
        send_paced(OP_READ, 3, 32'h0);
        send_paced(OP_W'(OP_DELETE + 1), 0, 32'h0);
        send_paced(OP_W'(OP_DELETE + 2), 1, 32'h0);
        send_paced(OP_LAST, 2, 32'h0);
        send_paced(OP_DELETE, -1, 32'h0);
        send_paced(OP_DELETE, 4, 32'h0);
        send_paced(OP_DELETE, 0, 32'h0);
        send_paced(OP_DELETE, 2, 32'h0);
        send_paced(OP_READ, 1, 32'h0);
        send_paced(OP_INS_POS, 1, 32'h5555_5555);
        send_paced(OP_INS_TAIL, -2048, 32'haaaa_aaaa);
        send_paced(OP_READ, 2047, 32'h0);
        wait_for_results();

        hold_requests++;
        repeat (100) send_random(40, 30, 20);
        wait_for_results();

        // fill the store
        while (sb.n_entries < CAPACITY) send_random(88, 4, 6);
        send_paced(OP_INS_POS, CAPACITY + 1, 32'h0);
        send_paced(OP_INS_POS, CAPACITY, 32'h1);
        send_paced(OP_INS_HEAD, 0, 32'h2);
        send_paced(OP_INS_TAIL, 0, 32'h3);

        hold_requests++;
        repeat (120) send_random(45, 15, 30);
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

// ===== indexed_list_store.f =====
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store.sv
rtl/ils_checker.sv
verif/testbench.sv
